>>> hdl/evq_pkg.sv
// ----------------------------------------------------------------------------
// evq_pkg
// Shared types, constants and helpers of the coalescing event queue.
// ----------------------------------------------------------------------------
package evq_pkg;

   localparam int NUM_EVENTS = 16;
   localparam int IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int ID_W       = 4;
   localparam int WIDE_W     = ID_W + IDX_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [ID_W-1:0]  id_type;

   typedef enum logic [1:0] {
      OP_ACTIVATE = 2'd0,
      OP_POLL     = 2'd1,
      OP_STOP     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      OUT_DONE     = 2'd0,
      OUT_DISPATCH = 2'd1,
      OUT_EMPTY    = 2'd2,
      OUT_STOPPED  = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      EV_IDLE   = 2'd0,
      EV_QUEUED = 2'd1,
      EV_AGAIN  = 2'd2
   } ev_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } evq_cmd_type;

   function automatic logic id_in_range(input id_type id);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(id);
      return w < WIDE_W'(NUM_EVENTS);
   endfunction

   function automatic idx_type id_to_idx(input id_type id);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(id);
      return w[IDX_W-1:0];
   endfunction

   function automatic id_type idx_to_id(input idx_type idx);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(idx);
      return w[ID_W-1:0];
   endfunction

endpackage

>>> hdl/evq_if.sv
// ----------------------------------------------------------------------------
// evq_req_if / evq_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface evq_req_if import evq_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] op;
   id_type     event_id;
   logic       gate_ok;

   modport source (output valid, op, event_id, gate_ok, input ready);
   modport sink   (input valid, op, event_id, gate_ok, output ready);
endinterface

interface evq_rsp_if import evq_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   id_type     dispatched_id;

   modport source (output valid, outcome, dispatched_id, input ready);
   modport sink   (input valid, outcome, dispatched_id, output ready);
endinterface

>>> hdl/coalescing_event_queue.sv
// ----------------------------------------------------------------------------
// coalescing_event_queue
// Flow: the item is captured in S_IDLE and updated in S_EXEC, which loads
// the result register; the update waits while an earlier result still
// waits on the output. A new item is taken only in S_IDLE, after the last
// update of the tables; a pending result does not block the next capture.
// Reset (synchronous): queue empty, all events idle, stop flag clear.
// ----------------------------------------------------------------------------
module coalescing_event_queue import evq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   evq_req_if.sink    req_chan,
   evq_rsp_if.source  rsp_chan
);

   evq_cmd_type cmd;

   evq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   evq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_chan.op),
      .req_event_id      (req_chan.event_id),
      .req_gate_ok       (req_chan.gate_ok),
      .rsp_outcome       (rsp_chan.outcome),
      .rsp_dispatched_id (rsp_chan.dispatched_id)
   );

endmodule

>>> hdl/evq_ctrl.sv
// ----------------------------------------------------------------------------
// evq_ctrl
// Sequencer: captures an item, runs its update once the result slot is free.
// ----------------------------------------------------------------------------
module evq_ctrl import evq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output evq_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == S_EXEC) && slot_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/evq_datapath.sv
// ----------------------------------------------------------------------------
// evq_datapath
// Event state table, link table, head/tail pointers and result register.
// ----------------------------------------------------------------------------
module evq_datapath import evq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  evq_cmd_type cmd,
   input  logic [1:0]  req_op,
   input  id_type      req_event_id,
   input  logic        req_gate_ok,
   output logic [1:0]  rsp_outcome,
   output id_type      rsp_dispatched_id
);

   logic [1:0]   op_ff;
   id_type       id_ff;
   logic         gate_ff;

   ev_state_type state_mem [NUM_EVENTS];
   idx_type      link_mem  [NUM_EVENTS];

   idx_type      head_ff, head_in;
   idx_type      tail_ff, tail_in;
   logic         empty_ff, empty_in;
   logic         stop_ff, stop_in;
   outcome_type  outcome_ff, outcome_in;
   id_type       disp_ff, disp_in;

   idx_type      ev_idx;
   ev_state_type ev_st;
   idx_type      head_link;
   logic         st_we;
   ev_state_type st_wdata;
   logic         link_we;
   idx_type      link_wdata;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         id_ff   <= req_event_id;
         gate_ff <= req_gate_ok;
      end
   end

   assign ev_idx    = (op_type'(op_ff) == OP_POLL) ? head_ff : id_to_idx(id_ff);
   assign ev_st     = state_mem[ev_idx];
   assign head_link = link_mem[head_ff];

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      empty_in   = empty_ff;
      stop_in    = stop_ff;
      outcome_in = OUT_DONE;
      disp_in    = '0;
      st_we      = 1'b0;
      st_wdata   = EV_IDLE;
      link_we    = 1'b0;
      link_wdata = ev_idx;
      case (op_type'(op_ff))
         OP_ACTIVATE: begin
            if (gate_ff && id_in_range(id_ff)) begin
               case (ev_st)
                  EV_IDLE: begin
                     st_we    = 1'b1;
                     st_wdata = EV_QUEUED;
                     tail_in  = ev_idx;
                     empty_in = 1'b0;
                     if (empty_ff) begin
                        head_in = ev_idx;
                     end else begin
                        link_we = 1'b1;
                     end
                  end
                  EV_QUEUED: begin
                     st_we    = 1'b1;
                     st_wdata = EV_AGAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_POLL: begin
            if (empty_ff) begin
               outcome_in = stop_ff ? OUT_STOPPED : OUT_EMPTY;
            end else begin
               outcome_in = OUT_DISPATCH;
               disp_in    = idx_to_id(head_ff);
               st_we      = 1'b1;
               if (ev_st == EV_IDLE || ev_st == EV_QUEUED) begin
                  st_wdata = EV_IDLE;
                  if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                  end else begin
                     head_in = head_link;
                  end
               end else begin
                  // requeue at tail unless it is the only entry
                  st_wdata = EV_QUEUED;
                  if (head_ff != tail_ff) begin
                     head_in = head_link;
                     link_we = 1'b1;
                     tail_in = head_ff;
                  end
               end
            end
         end
         OP_STOP: begin
            stop_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_EVENTS; i++) begin
            state_mem[i] <= EV_IDLE;
         end
      end else if (cmd.execute && st_we) begin
         state_mem[ev_idx] <= st_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && link_we) begin
         link_mem[tail_ff] <= link_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         stop_ff  <= 1'b0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         stop_ff  <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         outcome_ff <= outcome_in;
         disp_ff    <= disp_in;
      end
   end

   assign rsp_outcome       = outcome_ff;
   assign rsp_dispatched_id = disp_ff;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the coalescing event queue against a cycle-free model of its event
// table and FIFO: a directed table of corner cases, then random activate,
// poll, stop and unused-op items with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import evq_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DIR_N = 24;
   localparam int RAND_N = 1750;

   typedef struct packed {
      outcome_type outcome;
      id_type      id;
   } outcome_rec_type;

   typedef struct packed {
      logic [1:0]  op;
      id_type      id;
      logic        gate;
      logic        fixed;
      outcome_type want;
      id_type      want_id;
   } stim_row_type;

   localparam stim_row_type DIR_ROWS [DIR_N] = '{
      '{OP_POLL,     4'd0,  1'b0, 1'b1, OUT_EMPTY, 4'd0},
      '{OP_ACTIVATE, 4'd0,  1'b0, 1'b1, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b1, OUT_EMPTY, 4'd0},
      '{OP_ACTIVATE, 4'd15, 1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd0,  1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd15, 1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd15, 1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_UNUSED,   4'd10, 1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd0,  1'b0, 1'b1, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd15, 1'b0, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b1, OUT_EMPTY, 4'd0},
      '{OP_ACTIVATE, 4'd7,  1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd7,  1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b1, OUT_EMPTY, 4'd0},
      '{OP_ACTIVATE, 4'd3,  1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd12, 1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_ACTIVATE, 4'd3,  1'b1, 1'b1, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0},
      '{OP_POLL,     4'd0,  1'b1, 1'b0, OUT_DONE,  4'd0}
   };

   logic clock;
   logic reset;

   evq_req_if req_if ();
   evq_rsp_if rsp_if ();

   coalescing_event_queue u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // model of the event table and FIFO
   ev_state_type q_state [NUM_EVENTS];
   idx_type      q_link  [NUM_EVENTS];
   idx_type      q_head;
   idx_type      q_tail;
   logic         q_empty;
   logic         q_stop;

   outcome_rec_type pending_outcomes [$];
   logic            row_fixed;
   outcome_rec_type row_want;
   bit              calm;
   int              rsp_hold;
   int              errors;
   int              n_items;
   int              n_dispatch;
   int              n_empty;
   int              n_stopped;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_rec_type predict_outcome(input logic [1:0] op, input id_type id,
                                                       input logic gate);
      outcome_rec_type r;
      idx_type         ev;
      r.outcome = OUT_DONE;
      r.id = '0;
      case (op)
         OP_ACTIVATE: begin
            if (gate && int'(id) < NUM_EVENTS) begin
               ev = idx_type'(id);
               if (q_state[ev] == EV_IDLE) begin
                  q_state[ev] = EV_QUEUED;
                  if (q_empty) begin
                     q_head = ev;
                     q_tail = ev;
                     q_empty = 1'b0;
                  end else begin
                     q_link[q_tail] = ev;
                     q_tail = ev;
                  end
               end else if (q_state[ev] == EV_QUEUED) begin
                  q_state[ev] = EV_AGAIN;
               end
            end
         end
         OP_POLL: begin
            if (q_empty) begin
               r.outcome = q_stop ? OUT_STOPPED : OUT_EMPTY;
            end else begin
               ev = q_head;
               if (q_state[ev] == EV_IDLE || q_state[ev] == EV_QUEUED) begin
                  q_state[ev] = EV_IDLE;
                  if (ev == q_tail) q_empty = 1'b1;
                  else q_head = q_link[ev];
               end else begin
                  q_state[ev] = EV_QUEUED;
                  if (ev != q_tail) begin
                     q_head = q_link[ev];
                     q_link[q_tail] = ev;
                     q_tail = ev;
                  end
               end
               r.outcome = OUT_DISPATCH;
               r.id = id_type'(ev);
            end
         end
         OP_STOP: q_stop = 1'b1;
         default: ;
      endcase
      return r;
   endfunction

   task automatic issue_request(input logic [1:0] op, input id_type id, input logic gate,
                                input logic fixed, input outcome_rec_type want);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.event_id <= id;
      req_if.gate_ok  <= gate;
      row_fixed       <= fixed;
      row_want        <= want;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   always @(posedge clock) begin : watch
      outcome_rec_type r;
      if (!reset && req_if.valid && req_if.ready) begin
         r = predict_outcome(req_if.op, req_if.event_id, req_if.gate_ok);
         if (row_fixed) r = row_want;
         pending_outcomes.push_back(r);
         n_items++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, got outcome %0d id %0d", $time,
                     rsp_if.outcome, rsp_if.dispatched_id);
            errors++;
         end else begin
            r = pending_outcomes.pop_front();
            if (rsp_if.outcome !== r.outcome || rsp_if.dispatched_id !== r.id) begin
               $display("%0t: mismatch, expected outcome %0d id %0d, got outcome %0d id %0d",
                        $time, r.outcome, r.id, rsp_if.outcome, rsp_if.dispatched_id);
               errors++;
            end
            case (r.outcome)
               OUT_DISPATCH: n_dispatch++;
               OUT_EMPTY:    n_empty++;
               OUT_STOPPED:  n_stopped++;
               default: ;
            endcase
         end
         rsp_hold = calm ? 0 : $urandom_range(0, 4);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_if.ready <= !reset && rsp_hold == 0;
   end

   initial begin : stimulus
      outcome_rec_type want;
      int              pick;
      int              poll_pct;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = OP_ACTIVATE;
      req_if.event_id = '0;
      req_if.gate_ok = 1'b0;
      rsp_if.ready = 1'b0;
      row_fixed = 1'b0;
      row_want = '0;
      calm = 1'b0;
      rsp_hold = 0;
      errors = 0;
      n_items = 0;
      n_dispatch = 0;
      n_empty = 0;
      n_stopped = 0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
         q_state[i] = EV_IDLE;
         q_link[i] = '0;
      end
      q_head = '0;
      q_tail = '0;
      q_empty = 1'b1;
      q_stop = 1'b0;
      poll_pct = 30;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         want.outcome = DIR_ROWS[i].want;
         want.id = DIR_ROWS[i].want_id;
         issue_request(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].gate,
                       DIR_ROWS[i].fixed, want);
      end

      // switch at random between fill-heavy and drain-heavy phases; stop only late in the run
      want = '0;
      for (int i = 0; i < RAND_N; i++) begin
         if (i % 150 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            poll_pct = $urandom_range(0, 1) ? 60 : 25;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)
            issue_request(OP_UNUSED, id_type'($urandom), 1'($urandom), 1'b0, want);
         else if (pick < 7)
            issue_request(OP_ACTIVATE, id_type'($urandom), 1'b0, 1'b0, want);
         else if (pick < 9 && i > 1300)
            issue_request(OP_STOP, id_type'($urandom), 1'($urandom), 1'b0, want);
         else if ($urandom_range(0, 99) < poll_pct)
            issue_request(OP_POLL, id_type'($urandom), 1'($urandom), 1'b0, want);
         else
            issue_request(OP_ACTIVATE, id_type'($urandom), 1'b1, 1'b0, want);
      end
      req_if.valid <= 1'b0;
      calm = 1'b0;

      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("covered %0d items: %0d dispatches, %0d empty polls, %0d stopped polls",
               n_items, n_dispatch, n_empty, n_stopped);
      if (errors == 0) begin
         $display("[coalescing_event_queue] OK");
      end else begin
         $display("[coalescing_event_queue] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", pending_outcomes.size());
      $display("[coalescing_event_queue] ERROR");
      $finish;
   end

endmodule

>>> coalescing_event_queue.f
hdl/evq_pkg.sv
hdl/evq_if.sv
hdl/evq_ctrl.sv
hdl/evq_datapath.sv
hdl/coalescing_event_queue.sv
sim/testbench.sv
